@@ rtl/core/ppsf_pkg.sv @@
// ----------------------------------------------------------------------------
// ppsf_pkg
// Shared types and constants for the pixel plot shadow framebuffer.
// ----------------------------------------------------------------------------
package ppsf_pkg;

  // Controller command bytes
  localparam logic [7:0] CMD_EXT1        = 8'h30;
  localparam logic [7:0] CMD_COL_WINDOW  = 8'h15;
  localparam logic [7:0] CMD_PAGE_WINDOW = 8'h75;
  localparam logic [7:0] CMD_RAM_WRITE   = 8'h5c;

  // Positions within the nine-word bus sequence
  localparam int unsigned SEQ_W = 4;
  localparam logic [SEQ_W-1:0] SEQ_EXT1      = 4'd0;
  localparam logic [SEQ_W-1:0] SEQ_COL_CMD   = 4'd1;
  localparam logic [SEQ_W-1:0] SEQ_COL_LO    = 4'd2;
  localparam logic [SEQ_W-1:0] SEQ_COL_HI    = 4'd3;
  localparam logic [SEQ_W-1:0] SEQ_PAGE_CMD  = 4'd4;
  localparam logic [SEQ_W-1:0] SEQ_PAGE_LO   = 4'd5;
  localparam logic [SEQ_W-1:0] SEQ_PAGE_HI   = 4'd6;
  localparam logic [SEQ_W-1:0] SEQ_RAM_CMD   = 4'd7;
  localparam logic [SEQ_W-1:0] SEQ_DATA      = 4'd8;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture request word
    logic clr_wr;   // write zero at sweep address, advance sweep
    logic rd;       // read shadow byte at request address
    logic wr;       // write updated byte, hold it for the sequence
    logic idx_clr;  // restart sequence position
    logic idx_adv;  // advance sequence position
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_range;  // column and page inside the panel
    logic changed;   // requested bit differs from shadow
    logic clr_last;  // sweep at last entry
    logic seq_last;  // sequence at final word
  } status_t;

endpackage

@@ rtl/core/ppsf_plot_if.sv @@
// ----------------------------------------------------------------------------
// ppsf_plot_if
// Pixel plot request channel: column, row and on/off with valid/ready.
// ----------------------------------------------------------------------------
interface ppsf_plot_if;
  logic       valid;
  logic       ready;
  logic [7:0] column;
  logic [7:0] row;
  logic       pixel_on;

  modport source (output valid, output column, output row, output pixel_on, input ready);
  modport sink   (input valid, input column, input row, input pixel_on, output ready);
endinterface

@@ rtl/core/ppsf_bus_if.sv @@
// ----------------------------------------------------------------------------
// ppsf_bus_if
// Display controller bus channel: one byte with A0 and end mark per word.
// ----------------------------------------------------------------------------
interface ppsf_bus_if;
  logic       valid;
  logic       ready;
  logic [7:0] bus_byte;
  logic       is_data;
  logic       last;

  modport source (output valid, output bus_byte, output is_data, output last, input ready);
  modport sink   (input valid, input bus_byte, input is_data, input last, output ready);
endinterface

@@ rtl/core/ppsf_ctrl.sv @@
// ----------------------------------------------------------------------------
// ppsf_ctrl
// Sequencer: clearing sweep, request read/check, nine-word bus sequence.
// ----------------------------------------------------------------------------
module ppsf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ppsf_pkg::status_t status,
  output ppsf_pkg::cmd_t    cmd
);
  import ppsf_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_SEND
  } state_t;

  state_t state;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_SEND);

  always_comb begin
    cmd         = '0;
    cmd.clr_wr  = (state == ST_CLEAR);
    cmd.load    = in_valid && (state == ST_IDLE);
    cmd.rd      = (state == ST_READ) && status.in_range;
    cmd.wr      = (state == ST_CHECK) && status.changed;
    cmd.idx_clr = (state == ST_CHECK);
    cmd.idx_adv = (state == ST_SEND) && out_ready && !status.seq_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (status.clr_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) state <= ST_READ;
        end
        ST_READ: begin
          // drop requests outside the panel
          state <= status.in_range ? ST_CHECK : ST_IDLE;
        end
        ST_CHECK: begin
          state <= status.changed ? ST_SEND : ST_IDLE;
        end
        ST_SEND: begin
          if (out_ready && status.seq_last) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/ppsf_dp.sv @@
// ----------------------------------------------------------------------------
// ppsf_dp
// Datapath: request registers, shadow memory, bit update, bus word select.
// ----------------------------------------------------------------------------
module ppsf_dp #(
  parameter int NUM_COLUMNS = 256,
  parameter int NUM_PAGES   = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  ppsf_pkg::cmd_t    cmd,
  output ppsf_pkg::status_t status,
  input  logic [7:0]        column,
  input  logic [7:0]        row,
  input  logic              pixel_on,
  output logic [7:0]        bus_byte,
  output logic              is_data,
  output logic              last
);
  import ppsf_pkg::*;

  localparam int DEPTH  = NUM_COLUMNS * NUM_PAGES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]        mem [DEPTH];
  logic [7:0]        col_q;
  logic [7:0]        row_q;
  logic              on_q;
  logic [7:0]        rd_data;
  logic [7:0]        new_q;
  logic [ADDR_W-1:0] clr_addr;
  logic [SEQ_W-1:0]  idx;

  logic [4:0]        page;
  logic [7:0]        mask;
  logic [7:0]        new_byte;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  assign page = row_q[7:3];
  assign mask = 8'(1) << row_q[2:0];
  assign addr = ADDR_W'(32'(col_q) * NUM_PAGES + 32'(page));

  assign new_byte = on_q ? (rd_data | mask) : (rd_data & ~mask);

  assign status.in_range = ({1'b0, col_q} < 9'(NUM_COLUMNS)) &&
                           ({1'b0, page} < 6'(NUM_PAGES));
  assign status.changed  = (new_byte != rd_data);
  assign status.clr_last = (clr_addr == ADDR_W'(DEPTH - 1));
  assign status.seq_last = (idx == SEQ_DATA);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_q <= column;
      row_q <= row;
      on_q  <= pixel_on;
    end
    if (cmd.wr) new_q <= new_byte;
  end

  // sweep pointer for the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr && !status.clr_last) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= SEQ_EXT1;
    end else if (cmd.idx_clr) begin
      idx <= SEQ_EXT1;
    end else if (cmd.idx_adv) begin
      idx <= idx + SEQ_W'(1);
    end
  end

  assign wr_addr = cmd.clr_wr ? clr_addr : addr;
  assign wr_data = cmd.clr_wr ? 8'h00 : new_byte;

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.clr_wr || cmd.wr) mem[wr_addr] <= wr_data;
    if (cmd.rd) rd_data <= mem[addr];
  end

  always_comb begin
    bus_byte = CMD_EXT1;
    is_data  = 1'b0;
    last     = 1'b0;
    case (idx)
      SEQ_EXT1:     bus_byte = CMD_EXT1;
      SEQ_COL_CMD:  bus_byte = CMD_COL_WINDOW;
      SEQ_COL_LO,
      SEQ_COL_HI: begin
        bus_byte = col_q;
        is_data  = 1'b1;
      end
      SEQ_PAGE_CMD: bus_byte = CMD_PAGE_WINDOW;
      SEQ_PAGE_LO,
      SEQ_PAGE_HI: begin
        bus_byte = {3'b000, page};
        is_data  = 1'b1;
      end
      SEQ_RAM_CMD:  bus_byte = CMD_RAM_WRITE;
      SEQ_DATA: begin
        bus_byte = new_q;
        is_data  = 1'b1;
        last     = 1'b1;
      end
      default:      bus_byte = CMD_EXT1;
    endcase
  end

endmodule

@@ rtl/core/pixel_plot_shadow_framebuffer_unit.sv @@
// Timing: a changed pixel presents its first bus word after the shadow read and the bit check
//   states that follow the accepted plot word; only one plot word is handled at a time.
// Flow: a changed pixel passes accept, shadow read and check, then 9 bus words at one per
//   cycle while the sink is ready; unchanged plots end at check, off-panel ones at read.
// Reset: synchronous rst starts a clearing pass that zeroes all NUM_COLUMNS*NUM_PAGES shadow
//   bytes (5120 at the defaults); plot.ready stays low until it ends.
// ----------------------------------------------------------------------------
// pixel_plot_shadow_framebuffer_unit
// Pixel plot front end for a page-mode monochrome panel with a shadow copy.
// ----------------------------------------------------------------------------
module pixel_plot_shadow_framebuffer_unit #(
  parameter int NUM_COLUMNS = 256,
  parameter int NUM_PAGES   = 20
) (
  input  logic        clk,
  input  logic        rst,
  ppsf_plot_if.sink   plot,
  ppsf_bus_if.source  bus
);
  import ppsf_pkg::*;

  // Command and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  // The sequencer owns the handshakes: it takes one plot word at a time,
  // reads the shadow byte, checks whether the bit really changes, and
  // then walks the nine bus words. Payload comes from datapath registers
  // that hold steady while a bus word stalls.
  ppsf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (plot.valid),
    .in_ready  (plot.ready),
    .out_valid (bus.valid),
    .out_ready (bus.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Shadow memory holds one byte per column and 8-row page, addressed
  // column*NUM_PAGES + page. Off-panel requests never touch it.
  ppsf_dp #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_PAGES   (NUM_PAGES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .column   (plot.column),
    .row      (plot.row),
    .pixel_on (plot.pixel_on),
    .bus_byte (bus.bus_byte),
    .is_data  (bus.is_data),
    .last     (bus.last)
  );

`ifndef SYNTHESIS
  // Final word of the sequence is the data byte
  a_last_is_data: assert property (@(posedge clk) disable iff (rst)
    bus.valid && bus.last |-> bus.is_data)
    else $error("last word is not a data byte");

  // One item at a time: no new plot word while bus words are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    bus.valid |-> !plot.ready)
    else $error("plot accepted during bus sequence");

  // Clearing pass follows reset: no plot word taken right after it
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !plot.ready && !bus.valid)
    else $error("block active during clearing pass");

  // The last word is taken only when it closes the sequence
  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    bus.valid && bus.ready && bus.last |=> !bus.valid)
    else $error("bus sequence continues past last word");
`endif

endmodule
